// ----- src/acfc_pkg.sv -----
// acfc_pkg: shared constants, types and functions for the ascii frame crc checker
// used by ascii_frame_crc_checker; no dependencies
package acfc_pkg;

    // frame length limit, the byte counter saturates here
    localparam int FRAME_LIMIT = 256;
    localparam int COUNT_W     = $clog2(FRAME_LIMIT + 1);

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // sequence number limit and the saturated value above it
    localparam logic [16:0] SEQ_MAX  = 17'd65535;
    localparam logic [16:0] SEQ_SAT  = 17'd65536;

    // suffix length after the star
    localparam logic [2:0]  SUFFIX_LEN = 3'd4;
    localparam logic [2:0]  SUFFIX_SAT = 3'd7;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    // verdict codes
    typedef enum logic [1:0] {
        VERDICT_ACCEPTED    = 2'd0,
        VERDICT_CRC_BAD     = 2'd1,
        VERDICT_CMD_MISSING = 2'd2,
        VERDICT_DROPPED     = 2'd3
    } verdict_t;

    // decoded hex character
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    // hex character to nibble
    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t h;
        logic [7:0] d;
        h = '0;
        d = 8'h00;
        if (is_digit(b)) begin
            d = b - CH_0;
            h.valid = 1'b1;
        end else if ((b >= CH_UA) && (b <= CH_UF)) begin
            d = b - (CH_UA - 8'd10);
            h.valid = 1'b1;
        end else if ((b >= CH_LA) && (b <= CH_LF_HEX)) begin
            d = b - (CH_LA - 8'd10);
            h.valid = 1'b1;
        end
        h.value = d[3:0];
        return h;
    endfunction

endpackage

// ----- src/acfc_in_if.sv -----
// acfc_in_if: valid/ready channel carrying one frame byte per word
// no dependencies
interface acfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// ----- src/acfc_out_if.sv -----
// acfc_out_if: valid/ready channel carrying one frame verdict per word
// no dependencies
interface acfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [15:0] sequence_number;

    modport source (output valid, output verdict, output sequence_number, input ready);
    modport sink   (input valid, input verdict, input sequence_number, output ready);
endinterface

// ----- src/ascii_frame_crc_checker.sv -----
// ascii_frame_crc_checker: byte-wise checker of '@payload*HHHH' text frames
// depends on acfc_pkg, acfc_in_if, acfc_out_if
//
// a verdict is registered when the frame_end byte leaves the input stage
// throughput: one byte per cycle; bytes stall only while a finished verdict
//   waits in the result register and the next frame_end byte is ready to leave
// reset: rst_n clears the input stage and result valid flags and all frame state
module ascii_frame_crc_checker (
    input  logic        clk,
    input  logic        rst_n,
    acfc_in_if.sink     rx,
    acfc_out_if.source  res
);

    typedef enum logic [2:0] {
        TP_WAIT_SEQ = 3'd0,
        TP_IN_SEQ   = 3'd1,
        TP_WAIT_CMD = 3'd2,
        TP_CMD_SEEN = 3'd3,
        TP_SEQ_BAD  = 3'd4
    } token_phase_t;

    localparam logic [acfc_pkg::COUNT_W-1:0] LIMIT_C =
        acfc_pkg::COUNT_W'(acfc_pkg::FRAME_LIMIT);

    // input stage
    logic        stg_valid_reg;
    logic [7:0]  stg_byte_reg;
    logic        stg_last_reg;

    // result register
    logic        out_valid_reg;
    logic [1:0]  out_verdict_reg;
    logic [15:0] out_seq_reg;

    // frame state
    logic [15:0]                  crc_reg, crc_next;
    logic [15:0]                  crc_star_reg, crc_star_next;
    logic                         star_found_reg, star_found_next;
    logic [2:0]                   suffix_count_reg, suffix_count_next;
    logic [15:0]                  suffix_value_reg, suffix_value_next;
    logic                         suffix_bad_reg, suffix_bad_next;
    logic [acfc_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic                         line_cut_reg, line_cut_next;
    token_phase_t                 phase_reg, phase_next;
    logic [16:0]                  seq_reg, seq_next;
    token_phase_t                 phase_star_reg, phase_star_next;
    logic [16:0]                  seq_star_reg, seq_star_next;
    logic                         head_bad_reg, head_bad_next;
    logic                         string_end_reg, string_end_next;

    logic                 out_free;
    logic                 advance;
    logic                 dropped;
    acfc_pkg::verdict_t   verdict_next;
    logic [15:0]          seq_out_next;
    acfc_pkg::hex_digit_t hex;
    logic [19:0]          seq_times10;
    logic [3:0]           digit;

    // handshake: the stage moves unless a verdict cannot be placed
    assign out_free = !out_valid_reg || res.ready;
    assign advance  = stg_valid_reg && (!stg_last_reg || out_free);
    assign rx.ready = !stg_valid_reg || advance;

    assign res.valid           = out_valid_reg;
    assign res.verdict         = out_verdict_reg;
    assign res.sequence_number = out_seq_reg;

    assign hex         = acfc_pkg::hex_decode(stg_byte_reg);
    assign digit       = 4'(stg_byte_reg - acfc_pkg::CH_0);
    assign seq_times10 = ({3'b000, seq_reg} << 3) + ({3'b000, seq_reg} << 1)
                       + {16'h0000, digit};

    // frame state update for the byte in the input stage
    always_comb
    begin
        crc_next          = crc_reg;
        crc_star_next     = crc_star_reg;
        star_found_next   = star_found_reg;
        suffix_count_next = suffix_count_reg;
        suffix_value_next = suffix_value_reg;
        suffix_bad_next   = suffix_bad_reg;
        byte_count_next   = byte_count_reg;
        line_cut_next     = line_cut_reg;
        phase_next        = phase_reg;
        seq_next          = seq_reg;
        phase_star_next   = phase_star_reg;
        seq_star_next     = seq_star_reg;
        head_bad_next     = head_bad_reg;
        string_end_next   = string_end_reg;

        if (!string_end_reg)
        begin
            if (stg_byte_reg == acfc_pkg::CH_NUL)
            begin
                string_end_next = 1'b1;
            end
            else
            begin
                if (byte_count_reg < LIMIT_C)
                begin
                    byte_count_next = byte_count_reg + 1'b1;
                end
                if (byte_count_reg == '0)
                begin
                    if (stg_byte_reg != acfc_pkg::CH_AT)
                    begin
                        head_bad_next = 1'b1;
                    end
                end
                else if (!line_cut_reg)
                begin
                    if (stg_byte_reg == acfc_pkg::CH_CR || stg_byte_reg == acfc_pkg::CH_LF)
                    begin
                        line_cut_next = 1'b1;
                    end
                    else
                    begin
                        // suffix tracking, restarted at every star
                        if (stg_byte_reg == acfc_pkg::CH_STAR)
                        begin
                            crc_star_next     = crc_reg;
                            star_found_next   = 1'b1;
                            suffix_count_next = '0;
                            suffix_value_next = '0;
                            suffix_bad_next   = 1'b0;
                            phase_star_next   = phase_reg;
                            seq_star_next     = seq_reg;
                        end
                        else
                        begin
                            if (suffix_count_reg < acfc_pkg::SUFFIX_SAT)
                            begin
                                suffix_count_next = suffix_count_reg + 1'b1;
                            end
                            if (!hex.valid)
                            begin
                                suffix_bad_next = 1'b1;
                            end
                            else
                            begin
                                suffix_value_next = {suffix_value_reg[11:0], hex.value};
                            end
                        end

                        crc_next = acfc_pkg::crc_feed(crc_reg, stg_byte_reg);

                        // comma-separated token tracking
                        unique case (phase_reg)
                            TP_WAIT_SEQ:
                            begin
                                if (stg_byte_reg != acfc_pkg::CH_COMMA)
                                begin
                                    if (acfc_pkg::is_digit(stg_byte_reg))
                                    begin
                                        phase_next = TP_IN_SEQ;
                                        seq_next   = {13'h0000, digit};
                                    end
                                    else
                                    begin
                                        phase_next = TP_SEQ_BAD;
                                    end
                                end
                            end
                            TP_IN_SEQ:
                            begin
                                if (stg_byte_reg == acfc_pkg::CH_COMMA)
                                begin
                                    phase_next = TP_WAIT_CMD;
                                end
                                else if (acfc_pkg::is_digit(stg_byte_reg))
                                begin
                                    seq_next = (seq_times10 > 20'(acfc_pkg::SEQ_MAX))
                                             ? acfc_pkg::SEQ_SAT : seq_times10[16:0];
                                end
                                else
                                begin
                                    phase_next = TP_SEQ_BAD;
                                end
                            end
                            TP_WAIT_CMD:
                            begin
                                if (stg_byte_reg != acfc_pkg::CH_COMMA)
                                begin
                                    phase_next = TP_CMD_SEEN;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // verdict from the state after this byte
    always_comb
    begin
        dropped = head_bad_next || (byte_count_next == '0) || (byte_count_next >= LIMIT_C)
               || !star_found_next || (suffix_count_next != acfc_pkg::SUFFIX_LEN)
               || suffix_bad_next || (phase_star_next == TP_WAIT_SEQ)
               || (phase_star_next == TP_SEQ_BAD) || seq_star_next[16];
        seq_out_next = '0;
        if (dropped)
        begin
            verdict_next = acfc_pkg::VERDICT_DROPPED;
        end
        else
        begin
            seq_out_next = seq_star_next[15:0];
            priority if (crc_star_next != suffix_value_next)
            begin
                verdict_next = acfc_pkg::VERDICT_CRC_BAD;
            end
            else if (phase_star_next != TP_CMD_SEEN)
            begin
                verdict_next = acfc_pkg::VERDICT_CMD_MISSING;
            end
            else
            begin
                verdict_next = acfc_pkg::VERDICT_ACCEPTED;
            end
        end
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            crc_reg          <= acfc_pkg::CRC_INIT;
            crc_star_reg     <= '0;
            star_found_reg   <= 1'b0;
            suffix_count_reg <= '0;
            suffix_value_reg <= '0;
            suffix_bad_reg   <= 1'b0;
            byte_count_reg   <= '0;
            line_cut_reg     <= 1'b0;
            phase_reg        <= TP_WAIT_SEQ;
            seq_reg          <= '0;
            phase_star_reg   <= TP_WAIT_SEQ;
            seq_star_reg     <= '0;
            head_bad_reg     <= 1'b0;
            string_end_reg   <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                stg_valid_reg <= rx.valid;
            end

            // result valid: set by a finished frame, cleared when taken
            if (advance && stg_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (stg_last_reg)
                begin
                    crc_reg          <= acfc_pkg::CRC_INIT;
                    crc_star_reg     <= '0;
                    star_found_reg   <= 1'b0;
                    suffix_count_reg <= '0;
                    suffix_value_reg <= '0;
                    suffix_bad_reg   <= 1'b0;
                    byte_count_reg   <= '0;
                    line_cut_reg     <= 1'b0;
                    phase_reg        <= TP_WAIT_SEQ;
                    seq_reg          <= '0;
                    phase_star_reg   <= TP_WAIT_SEQ;
                    seq_star_reg     <= '0;
                    head_bad_reg     <= 1'b0;
                    string_end_reg   <= 1'b0;
                end
                else
                begin
                    crc_reg          <= crc_next;
                    crc_star_reg     <= crc_star_next;
                    star_found_reg   <= star_found_next;
                    suffix_count_reg <= suffix_count_next;
                    suffix_value_reg <= suffix_value_next;
                    suffix_bad_reg   <= suffix_bad_next;
                    byte_count_reg   <= byte_count_next;
                    line_cut_reg     <= line_cut_next;
                    phase_reg        <= phase_next;
                    seq_reg          <= seq_next;
                    phase_star_reg   <= phase_star_next;
                    seq_star_reg     <= seq_star_next;
                    head_bad_reg     <= head_bad_next;
                    string_end_reg   <= string_end_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            stg_byte_reg <= rx.data_byte;
            stg_last_reg <= rx.frame_end;
        end
        if (advance && stg_last_reg)
        begin
            out_verdict_reg <= verdict_next;
            out_seq_reg     <= seq_out_next;
        end
    end

endmodule
